/* hw/rtl/parking_bay_sensor_controller_core_macros.svh */
// Assertion macros for the parking bay sensor controller.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef PARKING_BAY_SENSOR_CONTROLLER_CORE_MACROS_SVH
`define PARKING_BAY_SENSOR_CONTROLLER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PBSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PBSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PBSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PBSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define PBSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/pbsc_pkg.sv */
// Shared types and constants of the parking bay sensor controller.
// No dependencies; used by pbsc_cfg_regs, pbsc_step and the controller core.
package pbsc_pkg;

    localparam logic [2:0] CFG_SAMPLE_PERIOD   = 3'd0;
    localparam logic [2:0] CFG_CLOSE_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_OPEN_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_FREE_ZONE       = 3'd3;
    localparam logic [2:0] CFG_STOP_ZONE       = 3'd4;
    localparam logic [2:0] CFG_CHANGE_THRESH   = 3'd5;
    localparam logic [2:0] CFG_CONFIRM_COUNT   = 3'd6;
    localparam logic [2:0] CFG_LOCATE_PERIOD   = 3'd7;

    localparam logic [9:0]  RST_SAMPLE_PERIOD  = 10'd100;
    localparam logic [13:0] RST_CLOSE_LIMIT    = 14'd150;
    localparam logic [13:0] RST_OPEN_LIMIT     = 14'd600;
    localparam logic [13:0] RST_FREE_ZONE      = 14'd800;
    localparam logic [13:0] RST_STOP_ZONE      = 14'd150;
    localparam logic [13:0] RST_CHANGE_THRESH  = 14'd50;
    localparam logic [2:0]  RST_CONFIRM_COUNT  = 3'd3;
    localparam logic [15:0] RST_LOCATE_PERIOD  = 16'd200;

    localparam logic [13:0] NO_READING         = 14'd9999;
    localparam logic [15:0] LASER_NONE         = 16'd60000;
    localparam logic [9:0]  ULTRA_MIN          = 10'd21;
    localparam logic [9:0]  ULTRA_MAX          = 10'd400;
    localparam logic [2:0]  LOCATE_STEPS       = 3'd6;
    localparam logic [15:0] BEEP_MIN_MS        = 16'd40;
    localparam logic [15:0] CNT_MAX            = 16'hFFFF;

    typedef struct packed {
        logic [9:0]  sample_period_ms;
        logic [13:0] close_limit_mm;
        logic [13:0] open_limit_mm;
        logic [13:0] free_zone_mm;
        logic [13:0] stop_zone_mm;
        logic [13:0] change_threshold_mm;
        logic [2:0]  confirm_count;
        logic [15:0] locate_period_ms;
    } t_cfg;

    typedef struct packed {
        logic [15:0] laser_mm;
        logic [9:0]  ultra_mm;
        logic        locate_one;
        logic        locate_two;
    } t_in;

    typedef struct packed {
        logic        bay_one_occupied;
        logic        bay_two_occupied;
        logic [31:0] bay_one_time_ms;
        logic [31:0] bay_two_time_ms;
        logic        gate_open;
        logic        led_red;
        logic        maneuver_beep;
        logic        locate_beep;
        logic [13:0] filtered_ultra_mm;
    } t_res;

    typedef struct packed {
        logic [13:0] stable_distance;
        logic [2:0]  mismatch_count;
        logic [31:0] bay_one_time;
        logic [31:0] bay_two_time;
        logic [2:0]  locate_steps_left;
        logic [15:0] since_locate_toggle;
        logic [15:0] since_beep_toggle;
        logic        beep_phase;
        logic        maneuver_level;
        logic        locate_level;
        logic        gate_raised;
    } t_state;

endpackage

/* hw/rtl/pbsc_if.sv */
// Valid/ready channel interfaces: sample requests, results, register writes.
// No dependencies.
interface pbsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] laser_mm;
    logic [9:0]  ultra_mm;
    logic        locate_one;
    logic        locate_two;

    modport source (output valid, laser_mm, ultra_mm, locate_one, locate_two, input ready);
    modport sink   (input valid, laser_mm, ultra_mm, locate_one, locate_two, output ready);
endinterface

interface pbsc_out_if;
    logic        valid;
    logic        ready;
    logic        bay_one_occupied;
    logic        bay_two_occupied;
    logic [31:0] bay_one_time_ms;
    logic [31:0] bay_two_time_ms;
    logic        gate_open;
    logic        led_red;
    logic        maneuver_beep;
    logic        locate_beep;
    logic [13:0] filtered_ultra_mm;

    modport source (output valid, bay_one_occupied, bay_two_occupied, bay_one_time_ms,
                    bay_two_time_ms, gate_open, led_red, maneuver_beep, locate_beep,
                    filtered_ultra_mm, input ready);
    modport sink   (input valid, bay_one_occupied, bay_two_occupied, bay_one_time_ms,
                    bay_two_time_ms, gate_open, led_red, maneuver_beep, locate_beep,
                    filtered_ultra_mm, output ready);
endinterface

interface pbsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pbsc_cfg_regs.sv */
// Configuration register file, written through the register write channel.
// Depends on pbsc_pkg and pbsc_cfg_if.
module pbsc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbsc_cfg_if.sink          i_cfg,
    output pbsc_pkg::t_cfg    o_cfg
);

    pbsc_pkg::t_cfg r_cfg;
    pbsc_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                pbsc_pkg::CFG_SAMPLE_PERIOD: n_cfg.sample_period_ms    = i_cfg.data[9:0];
                pbsc_pkg::CFG_CLOSE_LIMIT:   n_cfg.close_limit_mm      = i_cfg.data[13:0];
                pbsc_pkg::CFG_OPEN_LIMIT:    n_cfg.open_limit_mm       = i_cfg.data[13:0];
                pbsc_pkg::CFG_FREE_ZONE:     n_cfg.free_zone_mm        = i_cfg.data[13:0];
                pbsc_pkg::CFG_STOP_ZONE:     n_cfg.stop_zone_mm        = i_cfg.data[13:0];
                pbsc_pkg::CFG_CHANGE_THRESH: n_cfg.change_threshold_mm = i_cfg.data[13:0];
                pbsc_pkg::CFG_CONFIRM_COUNT: n_cfg.confirm_count       = i_cfg.data[2:0];
                pbsc_pkg::CFG_LOCATE_PERIOD: n_cfg.locate_period_ms    = i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period_ms    <= pbsc_pkg::RST_SAMPLE_PERIOD;
            r_cfg.close_limit_mm      <= pbsc_pkg::RST_CLOSE_LIMIT;
            r_cfg.open_limit_mm       <= pbsc_pkg::RST_OPEN_LIMIT;
            r_cfg.free_zone_mm        <= pbsc_pkg::RST_FREE_ZONE;
            r_cfg.stop_zone_mm        <= pbsc_pkg::RST_STOP_ZONE;
            r_cfg.change_threshold_mm <= pbsc_pkg::RST_CHANGE_THRESH;
            r_cfg.confirm_count       <= pbsc_pkg::RST_CONFIRM_COUNT;
            r_cfg.locate_period_ms    <= pbsc_pkg::RST_LOCATE_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* hw/rtl/pbsc_step.sv */
// Per-sample update: ultrasonic filter, occupancy timers, locate sequence,
// gate, red LED and maneuver beeper. Combinational; depends on pbsc_pkg.
module pbsc_step (
    input  pbsc_pkg::t_in     i_in,
    input  pbsc_pkg::t_state  i_state,
    input  pbsc_pkg::t_cfg    i_cfg,
    output pbsc_pkg::t_state  o_state,
    output pbsc_pkg::t_res    o_res
);

    pbsc_pkg::t_state n;
    logic [16:0] loc_sum;
    logic [16:0] beep_sum;
    logic [15:0] since_loc;
    logic [15:0] since_beep;
    logic [13:0] cur;
    logic [13:0] diff;
    logic [2:0]  mis_inc;
    logic [15:0] d1;
    logic [15:0] d1c;
    logic [15:0] d2w;
    logic [15:0] stop_w;
    logic [15:0] close_w;
    logic [15:0] open_w;
    logic [15:0] free_w;
    logic [15:0] dmin;
    logic        occ1;
    logic        occ2;
    logic [32:0] t1_sum;
    logic [32:0] t2_sum;
    logic        mov;
    logic [17:0] twice;
    logic [17:0] thrice;
    logic        beep_due;

    always_comb begin
        n       = i_state;
        d1      = i_in.laser_mm;
        stop_w  = {2'b0, i_cfg.stop_zone_mm};
        close_w = {2'b0, i_cfg.close_limit_mm};
        open_w  = {2'b0, i_cfg.open_limit_mm};
        free_w  = {2'b0, i_cfg.free_zone_mm};

        loc_sum   = {1'b0, i_state.since_locate_toggle} + {7'b0, i_cfg.sample_period_ms};
        beep_sum  = {1'b0, i_state.since_beep_toggle} + {7'b0, i_cfg.sample_period_ms};
        since_loc  = loc_sum[16] ? pbsc_pkg::CNT_MAX : loc_sum[15:0];
        since_beep = beep_sum[16] ? pbsc_pkg::CNT_MAX : beep_sum[15:0];

        cur = (i_in.ultra_mm >= pbsc_pkg::ULTRA_MIN && i_in.ultra_mm <= pbsc_pkg::ULTRA_MAX)
            ? {4'b0, i_in.ultra_mm} : pbsc_pkg::NO_READING;
        diff = (cur > i_state.stable_distance) ? cur - i_state.stable_distance
                                               : i_state.stable_distance - cur;
        mis_inc = i_state.mismatch_count + 3'd1;
        if (diff > i_cfg.change_threshold_mm) begin
            n.mismatch_count = mis_inc;
            if (mis_inc >= i_cfg.confirm_count || mis_inc == 3'd0) begin
                n.stable_distance = cur;
                n.mismatch_count  = 3'd0;
            end
        end else begin
            n.stable_distance = cur;
            n.mismatch_count  = 3'd0;
        end
        d2w = {2'b0, n.stable_distance};

        occ1   = d1 < stop_w;
        occ2   = d2w < stop_w;
        t1_sum = {1'b0, i_state.bay_one_time} + {23'b0, i_cfg.sample_period_ms};
        t2_sum = {1'b0, i_state.bay_two_time} + {23'b0, i_cfg.sample_period_ms};
        n.bay_one_time = occ1 ? (t1_sum[32] ? '1 : t1_sum[31:0]) : '0;
        n.bay_two_time = occ2 ? (t2_sum[32] ? '1 : t2_sum[31:0]) : '0;

        if ((i_in.locate_one && occ1) || (i_in.locate_two && occ2)) begin
            n.locate_steps_left = pbsc_pkg::LOCATE_STEPS;
        end
        n.since_locate_toggle = since_loc;
        if (n.locate_steps_left != 3'd0 && since_loc >= i_cfg.locate_period_ms) begin
            n.since_locate_toggle = '0;
            if (n.locate_steps_left[0]) begin
                n.locate_level = 1'b1;
            end else begin
                n.locate_level   = 1'b0;
                n.maneuver_level = 1'b0;
            end
            n.locate_steps_left = n.locate_steps_left - 3'd1;
            if (n.locate_steps_left == 3'd0) begin
                n.locate_level   = 1'b0;
                n.maneuver_level = 1'b0;
                n.beep_phase     = 1'b0;
            end
        end

        d1c = (d1 >= pbsc_pkg::LASER_NONE) ? {2'b0, pbsc_pkg::NO_READING} : d1;
        mov = (d1c > close_w && d1c < open_w) || (d2w > close_w && d2w < open_w);
        if (mov) begin
            n.gate_raised = 1'b1;
        end else if (d1c <= close_w || d2w <= close_w || (d1c >= open_w && d2w >= open_w)) begin
            n.gate_raised = 1'b0;
        end

        // floor(2*d/3) <= s  <=>  2*d <= 3*s + 2
        n.since_beep_toggle = since_beep;
        dmin     = (d1 < d2w) ? d1 : d2w;
        twice    = {1'b0, dmin, 1'b0};
        thrice   = {2'b0, since_beep} + {1'b0, since_beep, 1'b0} + 18'd2;
        beep_due = (since_beep >= pbsc_pkg::BEEP_MIN_MS) && (twice <= thrice);
        if (d1 <= stop_w || d2w <= stop_w) begin
            n.maneuver_level = 1'b0;
            n.beep_phase     = 1'b0;
        end else if ((d1 > stop_w && d1 < free_w) || (d2w > stop_w && d2w < free_w)) begin
            if (beep_due) begin
                n.beep_phase        = ~n.beep_phase;
                n.maneuver_level    = n.beep_phase;
                n.since_beep_toggle = '0;
            end
        end else begin
            n.maneuver_level = 1'b0;
            n.beep_phase     = 1'b0;
        end
    end

    assign o_state = n;

    assign o_res.bay_one_occupied  = occ1;
    assign o_res.bay_two_occupied  = occ2;
    assign o_res.bay_one_time_ms   = n.bay_one_time;
    assign o_res.bay_two_time_ms   = n.bay_two_time;
    assign o_res.gate_open         = n.gate_raised;
    assign o_res.led_red           = (d1c < free_w) || (d2w < free_w);
    assign o_res.maneuver_beep     = n.maneuver_level;
    assign o_res.locate_beep       = n.locate_level;
    assign o_res.filtered_ultra_mm = n.stable_distance;

endmodule

/* hw/rtl/parking_bay_sensor_controller_core.sv */
// Parking bay sensor controller: two bays, gate, LED and two beepers.
// Sample requests enter on i_in (one per sample period), results leave on o_out,
// registers are written on i_cfg (index 0..7, always ready).
// Each accepted request yields exactly one result, in order.
// A request is worked on by the per-sample logic while it sits in the
// input register and its result is loaded into the output register when the
// request advances, which raises o_out.valid. Throughput is one request per
// cycle while o_out.ready is high; the input register, per-sample logic and
// output register form a two-stage pipeline and the controller state updates
// in the cycle a request moves to the output.
// When o_out.ready is low the result holds, the state holds and one more
// request is taken into the input register before i_in.ready drops.
// Synchronous active-low reset clears both valid flags, loads the register
// defaults and the controller state reset values; no clearing pass follows.
// Write registers only while no request is in flight.
// Depends on pbsc_pkg, pbsc_if, pbsc_cfg_regs, pbsc_step and the macro header.
`include "parking_bay_sensor_controller_core_macros.svh"

module parking_bay_sensor_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbsc_in_if.sink     i_in,
    pbsc_out_if.source  o_out,
    pbsc_cfg_if.sink    i_cfg
);

    pbsc_pkg::t_cfg   cfg;
    pbsc_pkg::t_in    r_in;
    logic             r_in_vld;
    pbsc_pkg::t_res   r_out;
    logic             r_out_vld;
    pbsc_pkg::t_state r_state;
    pbsc_pkg::t_state n_state;
    pbsc_pkg::t_res   n_out;
    logic             advance;
    logic             in_take;

    pbsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pbsc_step u_step (
        .i_in    (r_in),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state.stable_distance     <= pbsc_pkg::NO_READING;
            r_state.mismatch_count      <= '0;
            r_state.bay_one_time        <= '0;
            r_state.bay_two_time        <= '0;
            r_state.locate_steps_left   <= '0;
            r_state.since_locate_toggle <= pbsc_pkg::CNT_MAX;
            r_state.since_beep_toggle   <= pbsc_pkg::CNT_MAX;
            r_state.beep_phase          <= 1'b0;
            r_state.maneuver_level      <= 1'b0;
            r_state.locate_level        <= 1'b0;
            r_state.gate_raised         <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.laser_mm   <= i_in.laser_mm;
            r_in.ultra_mm   <= i_in.ultra_mm;
            r_in.locate_one <= i_in.locate_one;
            r_in.locate_two <= i_in.locate_two;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.bay_one_occupied  = r_out.bay_one_occupied;
    assign o_out.bay_two_occupied  = r_out.bay_two_occupied;
    assign o_out.bay_one_time_ms   = r_out.bay_one_time_ms;
    assign o_out.bay_two_time_ms   = r_out.bay_two_time_ms;
    assign o_out.gate_open         = r_out.gate_open;
    assign o_out.led_red           = r_out.led_red;
    assign o_out.maneuver_beep     = r_out.maneuver_beep;
    assign o_out.locate_beep       = r_out.locate_beep;
    assign o_out.filtered_ultra_mm = r_out.filtered_ultra_mm;

    `PBSC_ASSERT_NEXT(a_state_hold_on_stall, i_clk, i_rst_n, r_out_vld && !o_out.ready, $stable(r_state), "state changed while result stalled")
    `PBSC_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, advance, r_out_vld, "advanced request produced no result")
    `PBSC_ASSERT_IMPLY(a_locate_level_in_seq, i_clk, i_rst_n, r_state.locate_level, r_state.locate_steps_left != 3'd0, "locate beeper on with no steps left")

endmodule

/* verif/tb_parking_bay_sensor_controller_core.sv */
// Self-checking bench for the parking bay sensor controller: directed table, then random
// sample streams under several register settings, with an in-bench predictor.
// Depends on pbsc_pkg, the pbsc_if channel interfaces and parking_bay_sensor_controller_core.
module tb_parking_bay_sensor_controller_core;
    import pbsc_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 500000;
    localparam int unsigned ITEMS_PER_PHASE  = 235;
    localparam int unsigned PHASES           = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DIRECTED_ROWS    = 23;

    typedef enum {REG_REALISTIC, REG_LOWEST, REG_HIGHEST, REG_SCRAMBLED, REG_DEFAULTS}
        t_reg_profile;

    typedef struct {
        t_in  stim;
        bit   pinned;
        t_res want;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pbsc_in_if  sample_ch ();
    pbsc_out_if result_ch ();
    pbsc_cfg_if cfg_ch ();

    parking_bay_sensor_controller_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (sample_ch),
        .o_out  (result_ch),
        .i_cfg  (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    t_cfg        regs;
    t_state      bay_st;
    t_res        pending_bay_reports [$];
    int unsigned samples_accepted = 0;
    int unsigned results_seen     = 0;
    int unsigned mismatches       = 0;
    int unsigned stray_results    = 0;
    int unsigned missing_results  = 0;
    int unsigned gap_pct          = 0;
    int unsigned stall_pct        = 0;
    int unsigned hold_offs        = 0;
    int unsigned watch_cycles;
    bit          hold_off_pending = 1'b0;
    int          lane_one_mm      = 900;
    int          lane_two_mm      = 400;

    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{'{16'd65535, 10'd0, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 14'd9999}},
        '{'{16'd0, 10'd1023, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 1'b0, 32'd100, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 14'd9999}},
        '{'{16'd0, 10'd0, 1'b0, 1'b0}, 1'b1,
          '{1'b1, 1'b0, 32'd200, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 14'd9999}},
        '{'{16'd0, 10'd0, 1'b0, 1'b0}, 1'b1,
          '{1'b1, 1'b0, 32'd300, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1, 14'd9999}},
        '{'{16'd65535, 10'd21, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd65535, 10'd21, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd65535, 10'd21, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd65535, 10'd400, 1'b0, 1'b1}, 1'b0, '0},
        '{'{16'd65535, 10'd20, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd65535, 10'd401, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd59999, 10'd100, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd60000, 10'd100, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd300, 10'd100, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd300, 10'd100, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd500, 10'd120, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd700, 10'd350, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd149, 10'd349, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd150, 10'd200, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd151, 10'd200, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd799, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd800, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd1, 10'd45, 1'b0, 1'b1}, 1'b0, '0},
        '{'{16'd65535, 10'd1023, 1'b1, 1'b1}, 1'b0, '0}
    };

    function automatic logic [15:0] clip_add16(input logic [15:0] a, input logic [9:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {7'b0, b};
        return s[16] ? CNT_MAX : s[15:0];
    endfunction

    function automatic logic [31:0] clip_add32(input logic [31:0] a, input logic [9:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {23'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_res predict_bay_result(input t_in s);
        t_res        r;
        logic [13:0] reading;
        logic [13:0] drift;
        logic [13:0] d2;
        logic [15:0] laser_seen;
        logic [15:0] nearest;
        logic [31:0] beep_interval;
        logic        one_taken;
        logic        two_taken;
        logic        in_zone;

        bay_st.since_locate_toggle = clip_add16(bay_st.since_locate_toggle,
                                                regs.sample_period_ms);
        bay_st.since_beep_toggle = clip_add16(bay_st.since_beep_toggle, regs.sample_period_ms);

        reading = (s.ultra_mm >= ULTRA_MIN && s.ultra_mm <= ULTRA_MAX) ?
                  {4'b0, s.ultra_mm} : NO_READING;
        drift = (reading > bay_st.stable_distance) ? reading - bay_st.stable_distance :
                                                     bay_st.stable_distance - reading;
        if (drift > regs.change_threshold_mm) begin
            bay_st.mismatch_count = bay_st.mismatch_count + 3'd1;
            if (bay_st.mismatch_count >= regs.confirm_count || bay_st.mismatch_count == 3'd0) begin
                bay_st.stable_distance = reading;
                bay_st.mismatch_count  = 3'd0;
            end
        end else begin
            bay_st.stable_distance = reading;
            bay_st.mismatch_count  = 3'd0;
        end
        d2 = bay_st.stable_distance;

        one_taken = s.laser_mm < regs.stop_zone_mm;
        two_taken = d2 < regs.stop_zone_mm;
        bay_st.bay_one_time = one_taken ? clip_add32(bay_st.bay_one_time, regs.sample_period_ms)
                                        : 32'd0;
        bay_st.bay_two_time = two_taken ? clip_add32(bay_st.bay_two_time, regs.sample_period_ms)
                                        : 32'd0;

        if ((s.locate_one && one_taken) || (s.locate_two && two_taken))
            bay_st.locate_steps_left = LOCATE_STEPS;
        if (bay_st.locate_steps_left != 3'd0 &&
            bay_st.since_locate_toggle >= regs.locate_period_ms) begin
            bay_st.since_locate_toggle = 16'd0;
            if (bay_st.locate_steps_left[0]) begin
                bay_st.locate_level = 1'b1;
            end else begin
                bay_st.locate_level   = 1'b0;
                bay_st.maneuver_level = 1'b0;
            end
            bay_st.locate_steps_left = bay_st.locate_steps_left - 3'd1;
            if (bay_st.locate_steps_left == 3'd0) begin
                bay_st.locate_level   = 1'b0;
                bay_st.maneuver_level = 1'b0;
                bay_st.beep_phase     = 1'b0;
            end
        end

        laser_seen = (s.laser_mm >= LASER_NONE) ? {2'b0, NO_READING} : s.laser_mm;
        in_zone = (laser_seen > regs.close_limit_mm && laser_seen < regs.open_limit_mm) ||
                  (d2 > regs.close_limit_mm && d2 < regs.open_limit_mm);
        if (in_zone)
            bay_st.gate_raised = 1'b1;
        else if (laser_seen <= regs.close_limit_mm || d2 <= regs.close_limit_mm ||
                 (laser_seen >= regs.open_limit_mm && d2 >= regs.open_limit_mm))
            bay_st.gate_raised = 1'b0;

        if (s.laser_mm <= regs.stop_zone_mm || d2 <= regs.stop_zone_mm) begin
            bay_st.maneuver_level = 1'b0;
            bay_st.beep_phase     = 1'b0;
        end else if ((s.laser_mm > regs.stop_zone_mm && s.laser_mm < regs.free_zone_mm) ||
                     (d2 > regs.stop_zone_mm && d2 < regs.free_zone_mm)) begin
            nearest = (s.laser_mm < {2'b0, d2}) ? s.laser_mm : {2'b0, d2};
            beep_interval = ({16'b0, nearest} << 1) / 32'd3;
            if (beep_interval < {16'b0, BEEP_MIN_MS})
                beep_interval = {16'b0, BEEP_MIN_MS};
            if ({16'b0, bay_st.since_beep_toggle} >= beep_interval) begin
                bay_st.beep_phase        = ~bay_st.beep_phase;
                bay_st.maneuver_level    = bay_st.beep_phase;
                bay_st.since_beep_toggle = 16'd0;
            end
        end else begin
            bay_st.maneuver_level = 1'b0;
            bay_st.beep_phase     = 1'b0;
        end

        r.bay_one_occupied  = one_taken;
        r.bay_two_occupied  = two_taken;
        r.bay_one_time_ms   = bay_st.bay_one_time;
        r.bay_two_time_ms   = bay_st.bay_two_time;
        r.gate_open         = bay_st.gate_raised;
        r.led_red           = (laser_seen < regs.free_zone_mm) || (d2 < regs.free_zone_mm);
        r.maneuver_beep     = bay_st.maneuver_level;
        r.locate_beep       = bay_st.locate_level;
        r.filtered_ultra_mm = bay_st.stable_distance;
        return r;
    endfunction

    function automatic t_in next_sample();
        t_in s;
        int  step;
        s.locate_one = ($urandom_range(0, 9) == 0);
        s.locate_two = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 99) < 8) begin
            s.laser_mm = 16'($urandom_range(0, 65535));
            s.ultra_mm = 10'($urandom_range(0, 1023));
            return s;
        end
        if ($urandom_range(0, 19) == 0) begin
            lane_one_mm = int'($urandom_range(0, 1200));
        end else begin
            step = int'($urandom_range(0, 80)) - 40;
            lane_one_mm = lane_one_mm + step;
            if (lane_one_mm < 0) lane_one_mm = 0;
            if (lane_one_mm > 1200) lane_one_mm = 1200;
        end
        if ($urandom_range(0, 14) == 0)
            s.laser_mm = 16'($urandom_range(60000, 65535));
        else
            s.laser_mm = 16'(lane_one_mm);
        if ($urandom_range(0, 24) == 0) begin
            lane_two_mm = int'($urandom_range(0, 450));
        end else if ($urandom_range(0, 1) == 0) begin
            step = int'($urandom_range(0, 50)) - 25;
            lane_two_mm = lane_two_mm + step;
            if (lane_two_mm < 0) lane_two_mm = 0;
            if (lane_two_mm > 450) lane_two_mm = 450;
        end
        if ($urandom_range(0, 11) == 0)
            s.ultra_mm = 10'($urandom_range(0, 1023));
        else
            s.ultra_mm = 10'(lane_two_mm + int'($urandom_range(0, 2)));
        return s;
    endfunction

    task automatic offer_sample(input t_in s, input bit pinned, input t_res want);
        t_res predicted;
        sample_ch.valid      <= 1'b1;
        sample_ch.laser_mm   <= s.laser_mm;
        sample_ch.ultra_mm   <= s.ultra_mm;
        sample_ch.locate_one <= s.locate_one;
        sample_ch.locate_two <= s.locate_two;
        do @(posedge i_clk); while (!sample_ch.ready);
        predicted = predict_bay_result(s);
        pending_bay_reports.push_back(pinned ? want : predicted);
        samples_accepted++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic program_regs(input t_reg_profile prof);
        logic [15:0] vals [8];
        int unsigned k;
        case (prof)
            REG_LOWEST:    vals = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1};
            REG_HIGHEST:   vals = '{16'd1000, 16'd9999, 16'd9999, 16'd9999, 16'd9999,
                                    16'd9999, 16'd7, 16'd65535};
            REG_DEFAULTS:  vals = '{16'(RST_SAMPLE_PERIOD), 16'(RST_CLOSE_LIMIT),
                                    16'(RST_OPEN_LIMIT), 16'(RST_FREE_ZONE),
                                    16'(RST_STOP_ZONE), 16'(RST_CHANGE_THRESH),
                                    16'(RST_CONFIRM_COUNT), RST_LOCATE_PERIOD};
            REG_SCRAMBLED: begin
                for (k = 0; k < 8; k++) vals[k] = 16'($urandom_range(0, 65535));
            end
            default: begin
                vals[CFG_SAMPLE_PERIOD] = 16'($urandom_range(1, 1000));
                vals[CFG_CLOSE_LIMIT]   = 16'($urandom_range(0, 300));
                vals[CFG_OPEN_LIMIT]    = vals[CFG_CLOSE_LIMIT] + 16'($urandom_range(0, 600));
                vals[CFG_FREE_ZONE]     = vals[CFG_OPEN_LIMIT] + 16'($urandom_range(0, 400));
                vals[CFG_STOP_ZONE]     = 16'($urandom_range(0, 300));
                vals[CFG_CHANGE_THRESH] = 16'($urandom_range(0, 120));
                vals[CFG_CONFIRM_COUNT] = 16'($urandom_range(0, 7));
                vals[CFG_LOCATE_PERIOD] = 16'($urandom_range(1, 2000));
            end
        endcase
        for (k = 0; k < 8; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= 3'(k);
            cfg_ch.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (3'(k))
                CFG_SAMPLE_PERIOD: regs.sample_period_ms    = vals[k][9:0];
                CFG_CLOSE_LIMIT:   regs.close_limit_mm      = vals[k][13:0];
                CFG_OPEN_LIMIT:    regs.open_limit_mm       = vals[k][13:0];
                CFG_FREE_ZONE:     regs.free_zone_mm        = vals[k][13:0];
                CFG_STOP_ZONE:     regs.stop_zone_mm        = vals[k][13:0];
                CFG_CHANGE_THRESH: regs.change_threshold_mm = vals[k][13:0];
                CFG_CONFIRM_COUNT: regs.confirm_count       = vals[k][2:0];
                CFG_LOCATE_PERIOD: regs.locate_period_ms    = vals[k];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : report_check
        t_res got;
        t_res want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.bay_one_occupied  = result_ch.bay_one_occupied;
            got.bay_two_occupied  = result_ch.bay_two_occupied;
            got.bay_one_time_ms   = result_ch.bay_one_time_ms;
            got.bay_two_time_ms   = result_ch.bay_two_time_ms;
            got.gate_open         = result_ch.gate_open;
            got.led_red           = result_ch.led_red;
            got.maneuver_beep     = result_ch.maneuver_beep;
            got.locate_beep       = result_ch.locate_beep;
            got.filtered_ultra_mm = result_ch.filtered_ultra_mm;
            results_seen++;
            if (pending_bay_reports.size() == 0) begin
                stray_results++;
                if (stray_results <= 10)
                    $display("Unexpected result %0d with no sample pending", results_seen);
            end else begin
                want = pending_bay_reports.pop_front();
                if (got.bay_one_occupied !== want.bay_one_occupied)
                    note_mismatch("bay_one_occupied", 32'(want.bay_one_occupied),
                                  32'(got.bay_one_occupied));
                if (got.bay_two_occupied !== want.bay_two_occupied)
                    note_mismatch("bay_two_occupied", 32'(want.bay_two_occupied),
                                  32'(got.bay_two_occupied));
                if (got.bay_one_time_ms !== want.bay_one_time_ms)
                    note_mismatch("bay_one_time_ms", want.bay_one_time_ms, got.bay_one_time_ms);
                if (got.bay_two_time_ms !== want.bay_two_time_ms)
                    note_mismatch("bay_two_time_ms", want.bay_two_time_ms, got.bay_two_time_ms);
                if (got.gate_open !== want.gate_open)
                    note_mismatch("gate_open", 32'(want.gate_open), 32'(got.gate_open));
                if (got.led_red !== want.led_red)
                    note_mismatch("led_red", 32'(want.led_red), 32'(got.led_red));
                if (got.maneuver_beep !== want.maneuver_beep)
                    note_mismatch("maneuver_beep", 32'(want.maneuver_beep),
                                  32'(got.maneuver_beep));
                if (got.locate_beep !== want.locate_beep)
                    note_mismatch("locate_beep", 32'(want.locate_beep), 32'(got.locate_beep));
                if (got.filtered_ultra_mm !== want.filtered_ultra_mm)
                    note_mismatch("filtered_ultra_mm", 32'(want.filtered_ultra_mm),
                                  32'(got.filtered_ultra_mm));
            end
        end
    end

    initial begin : result_sink
        int unsigned held;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                result_ch.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge i_clk);
        $display("Run stopped at the cycle limit with %0d results outstanding",
                 samples_accepted - results_seen);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_reg_profile plan [PHASES];
        int unsigned  phase;
        int unsigned  n;
        plan = '{REG_REALISTIC, REG_LOWEST, REG_REALISTIC, REG_HIGHEST,
                 REG_SCRAMBLED, REG_REALISTIC, REG_SCRAMBLED, REG_DEFAULTS};
        sample_ch.valid      = 1'b0;
        sample_ch.laser_mm   = '0;
        sample_ch.ultra_mm   = '0;
        sample_ch.locate_one = 1'b0;
        sample_ch.locate_two = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        regs = '{RST_SAMPLE_PERIOD, RST_CLOSE_LIMIT, RST_OPEN_LIMIT, RST_FREE_ZONE,
                 RST_STOP_ZONE, RST_CHANGE_THRESH, RST_CONFIRM_COUNT, RST_LOCATE_PERIOD};
        bay_st = '{stable_distance: NO_READING, since_locate_toggle: CNT_MAX,
                   since_beep_toggle: CNT_MAX, default: '0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        for (n = 0; n < DIRECTED_ROWS; n++)
            offer_sample(directed_rows[n].stim, directed_rows[n].pinned, directed_rows[n].want);
        sample_ch.valid <= 1'b0;
        while (results_seen < samples_accepted) @(posedge i_clk);

        for (phase = 0; phase < PHASES; phase++) begin
            program_regs(plan[phase]);
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            end
            if (phase == 2 || phase == 5) begin
                hold_off_pending = 1'b1;
                hold_offs++;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                offer_sample(next_sample(), 1'b0, '0);
            sample_ch.valid <= 1'b0;
            while (results_seen < samples_accepted) @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        missing_results = pending_bay_reports.size();
        $display("Covered %0d directed and %0d random samples over %0d register settings, %0d long receiver hold-offs.",
                 DIRECTED_ROWS, PHASES * ITEMS_PER_PHASE, PHASES, hold_offs);
        $display("Checked %0d results: %0d field mismatches, %0d unexpected, %0d missing.",
                 results_seen, mismatches, stray_results, missing_results);
        if (mismatches == 0 && stray_results == 0 && missing_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
